// ----- rtl/core/ipt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the indirect pattern table.
// Depends on nothing; used by ipt_cfg, the top level and the testbench.
package ipt_pkg;

  localparam int ADDR_W = 31;
  localparam int VAL_W = 32;
  localparam int HIT_W = 4;
  localparam int REM_W = 5;
  localparam int IV_W = 10;
  localparam int WIN_W = 12;
  localparam int PH_W = 4;
  localparam int LIM_W = 13;
  localparam int AW = 4;

  localparam logic [HIT_W-1:0] HIT_MAX = 4'd15;
  localparam logic [HIT_W-1:0] STALE_HITS = 4'd3;
  localparam logic [REM_W-1:0] REM_MAX = 5'd31;

  localparam logic ACT_ACCESS = 1'b0;
  localparam logic ACT_ADD = 1'b1;

  localparam logic [1:0] REG_INTERVAL = 2'd0;
  localparam logic [1:0] REG_WINDOW = 2'd1;
  localparam logic [1:0] REG_PHITS = 2'd2;

  localparam logic [IV_W-1:0] INTERVAL_RST = 10'd5;
  localparam logic [WIN_W-1:0] WINDOW_RST = 12'd20;
  localparam logic [PH_W-1:0] PHITS_RST = 4'd4;

  typedef struct packed {
    logic [LIM_W-1:0] limit;
    logic [WIN_W-1:0] window;
    logic [PH_W-1:0] phits;
  } cfg_t;

  typedef struct packed {
    logic dropped;
    logic created;
    logic [REM_W-1:0] removed;
    logic pf_on;
    logic started;
    logic is_index;
  } res_t;

endpackage

// ----- rtl/core/ipt_cfg.sv -----
`timescale 1ns / 1ps
// Configuration registers behind the APB-style port.
// Depends on ipt_pkg.
module ipt_cfg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ipt_pkg::AW-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output ipt_pkg::cfg_t          cfg
);

  logic [ipt_pkg::IV_W-1:0] interval;
  logic [ipt_pkg::WIN_W-1:0] window;
  logic [ipt_pkg::PH_W-1:0] phits;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= ipt_pkg::INTERVAL_RST;
      window <= ipt_pkg::WINDOW_RST;
      phits <= ipt_pkg::PHITS_RST;
    end else if (wr) begin
      case (paddr[3:2])
        ipt_pkg::REG_INTERVAL: interval <= pwdata[ipt_pkg::IV_W-1:0];
        ipt_pkg::REG_WINDOW: window <= pwdata[ipt_pkg::WIN_W-1:0];
        ipt_pkg::REG_PHITS: phits <= pwdata[ipt_pkg::PH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ipt_pkg::REG_INTERVAL: prdata = {22'd0, interval};
      ipt_pkg::REG_WINDOW: prdata = {20'd0, window};
      ipt_pkg::REG_PHITS: prdata = {28'd0, phits};
      default: prdata = 32'd0;
    endcase
  end

  assign cfg.limit = {3'd0, interval} + {1'b0, interval, 2'b00};
  assign cfg.window = window;
  assign cfg.phits = phits;

endmodule

// ----- rtl/core/ipt_tgt_mem.sv -----
`timescale 1ns / 1ps
// Target address memory: one row of predicted targets per table entry.
// Registered read; depends on nothing.
module ipt_tgt_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 256,
  parameter int AWID = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AWID-1:0]  waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AWID-1:0]  raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/indirect_pattern_table.sv -----
`timescale 1ns / 1ps
// Indirect pattern table top level: sequencer, entry registers, result register.
// An add item scans every entry in turn (ADD_SCAN), then updates one entry (ADD_WR).
// An access item reads each entry's target row, then compares it on the shared unit, entry by
// entry; when no entry claims it as an index, a second pass does the same for every entry.
// One item at a time; the last state (FIN) waits only while a result is unread.
// Synchronous reset clears entry and target valid bits, the prefetch flag and the registers.
module indirect_pattern_table #(
  parameter int ENTRIES = 16,
  parameter int TARGETS_PER_ENTRY = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // access_address[30:0], index_value[62:31], tick[93:63], base_address[124:94],
  // index_load_address[155:125], zero fill [159:156]
  input  logic [159:0]           s_tdata,
  // action[0]
  input  logic [0:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // is_index[0], prefetch_started[1], prefetch_on[2], entries_removed[7:3],
  // entry_created[8], add_dropped[9], zero fill [15:10]
  output logic [15:0]            m_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ipt_pkg::AW-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TW = (TARGETS_PER_ENTRY > 1) ? $clog2(TARGETS_PER_ENTRY) : 1;
  localparam int VW = ipt_pkg::VAL_W;
  localparam int RW = TARGETS_PER_ENTRY * VW;
  localparam int AD = ipt_pkg::ADDR_W;

  typedef enum logic [2:0] {IDLE, ADD_SCAN, ADD_WR, A1_RD, A1_PR, A2_RD, A2_PR, FIN} state_t;

  state_t state;
  logic [EW-1:0] idx;
  logic [AD-1:0] addr, tick, base, iaddr;
  logic [VW-1:0] value;
  logic is_index, started, pflag, created, dropped;
  logic [ipt_pkg::REM_W-1:0] removed;
  logic found, freef;
  logic [EW-1:0] fidx, freeidx;

  logic ev [ENTRIES];
  logic epf [ENTRIES];
  logic [AD-1:0] ebase [ENTRIES];
  logic [AD-1:0] eli [ENTRIES];
  logic [AD-1:0] etick [ENTRIES];
  logic [ipt_pkg::HIT_W-1:0] ehits [ENTRIES];
  logic [TARGETS_PER_ENTRY-1:0] tvld [ENTRIES];

  ipt_pkg::cfg_t cfg;
  ipt_pkg::res_t res;

  logic [RW-1:0] row, wrow;
  logic mem_we;
  logic [TARGETS_PER_ENTRY-1:0] vb, eqv;
  logic [VW-1:0] tgt, cmp;
  logic dup, hasfree, claim, hit, st_now, stale, last;
  logic [TW-1:0] slot;
  logic signed [VW-1:0] idx_gap, age;
  logic [ipt_pkg::HIT_W-1:0] nh;

  ipt_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  ipt_tgt_mem #(.DEPTH(ENTRIES), .WIDTH(RW), .AWID(EW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(idx), .wdata(wrow), .raddr(idx), .rdata(row)
  );

  assign s_tready = (state == IDLE);
  assign last = (idx == EW'(ENTRIES - 1));

  always_comb begin
    vb = tvld[idx];
    tgt = {value[VW-3:0], 2'b00} + {1'b0, ebase[idx]};
    cmp = (state == A1_PR) ? tgt : {1'b0, addr};
    hasfree = 1'b0;
    slot = '0;
    for (int k = 0; k < TARGETS_PER_ENTRY; k++) begin
      eqv[k] = vb[k] && (row[k*VW +: VW] == cmp);
      if (!vb[k] && !hasfree) begin
        hasfree = 1'b1;
        slot = TW'(k);
      end
    end
    dup = |eqv;
    hit = |eqv;
    idx_gap = $signed({1'b0, addr} - {1'b0, eli[idx]});
    claim = ev[idx] && !epf[idx] && (idx_gap <= $signed({20'd0, cfg.window}));
    wrow = row;
    wrow[slot*VW +: VW] = tgt;
    mem_we = (state == A1_PR) && claim && !dup && hasfree;
    nh = (hit && ehits[idx] != ipt_pkg::HIT_MAX) ? ehits[idx] + 4'd1 : ehits[idx];
    st_now = ev[idx] && hit && (nh > cfg.phits);
    age = $signed({1'b0, tick} - {1'b0, (st_now ? tick : etick[idx])});
    stale = ev[idx] && (age > $signed({19'd0, cfg.limit})) && !(epf[idx] || st_now)
            && (nh < ipt_pkg::STALE_HITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      idx <= '0;
      m_tvalid <= 1'b0;
      pflag <= 1'b0;
      for (int e = 0; e < ENTRIES; e++) begin
        ev[e] <= 1'b0;
        tvld[e] <= '0;
      end
    end else begin
      if (m_tvalid && m_tready && state != FIN) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            addr <= s_tdata[30:0];
            value <= s_tdata[62:31];
            tick <= s_tdata[93:63];
            base <= s_tdata[124:94];
            iaddr <= s_tdata[155:125];
            is_index <= 1'b0;
            started <= 1'b0;
            removed <= '0;
            created <= 1'b0;
            dropped <= 1'b0;
            found <= 1'b0;
            freef <= 1'b0;
            idx <= '0;
            state <= (s_tuser[0] == ipt_pkg::ACT_ADD) ? ADD_SCAN : A1_RD;
          end
        end
        ADD_SCAN: begin
          if (ev[idx] && ebase[idx] == base && !found) begin
            found <= 1'b1;
            fidx <= idx;
          end
          if (!ev[idx] && !freef) begin
            freef <= 1'b1;
            freeidx <= idx;
          end
          if (last) begin
            state <= ADD_WR;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ADD_WR: begin
          if (found) begin
            eli[fidx] <= iaddr;
            etick[fidx] <= tick;
          end else if (freef) begin
            ev[freeidx] <= 1'b1;
            ebase[freeidx] <= base;
            eli[freeidx] <= iaddr;
            etick[freeidx] <= tick;
            ehits[freeidx] <= '0;
            epf[freeidx] <= 1'b0;
            tvld[freeidx] <= '0;
            created <= 1'b1;
          end else begin
            dropped <= 1'b1;
          end
          state <= FIN;
        end
        A1_RD: state <= A1_PR;
        A1_PR: begin
          if (claim) begin
            if (mem_we) begin
              tvld[idx][slot] <= 1'b1;
            end
            eli[idx] <= addr;
            is_index <= 1'b1;
          end
          if (last) begin
            idx <= '0;
            state <= (is_index || claim) ? FIN : A2_RD;
          end else begin
            idx <= idx + 1'b1;
            state <= A1_RD;
          end
        end
        A2_RD: state <= A2_PR;
        A2_PR: begin
          if (ev[idx]) begin
            ehits[idx] <= nh;
            if (st_now) begin
              epf[idx] <= 1'b1;
              pflag <= 1'b1;
              etick[idx] <= tick;
              tvld[idx] <= '0;
              started <= 1'b1;
            end
            if (stale) begin
              ev[idx] <= 1'b0;
              tvld[idx] <= '0;
              if (removed != ipt_pkg::REM_MAX) begin
                removed <= removed + 1'b1;
              end
            end
          end
          if (last) begin
            state <= FIN;
          end else begin
            idx <= idx + 1'b1;
            state <= A2_RD;
          end
        end
        FIN: begin
          if (!m_tvalid || m_tready) begin
            res.is_index <= is_index;
            res.started <= started;
            res.pf_on <= pflag;
            res.removed <= removed;
            res.created <= created;
            res.dropped <= dropped;
            m_tvalid <= 1'b1;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign m_tdata = {6'd0, res};

  a_created_dropped: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[8] && m_tdata[9])) else $error("created and dropped both set");
  a_claim_no_remove: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[7:3] == 5'd0 && !m_tdata[1])
    else $error("claimed access also removed or started");
  a_flag_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> !$fell(pflag)) else $error("prefetch flag cleared");
  a_idle_at_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state != IDLE) else $error("item accepted but sequencer idle");

endmodule

// ----- bench/indirect_pattern_table_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the indirect pattern table: stream stimulus, APB setup,
// and a behavioral predictor of the table state. Depends on ipt_pkg and the RTL.
module indirect_pattern_table_tb;

  localparam int NENT = 16;
  localparam int NTGT = 8;
  localparam int MAX_CYCLES = 1500000;

  typedef struct packed {
    logic dropped;
    logic created;
    logic [4:0] removed;
    logic pf_on;
    logic started;
    logic is_index;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [159:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ipt_pkg::AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  indirect_pattern_table DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state.
  logic [9:0] cur_interval;
  logic [11:0] cur_window;
  logic [3:0] cur_phits;
  logic ent_valid[NENT];
  logic [30:0] ent_base[NENT];
  logic [30:0] ent_last[NENT];
  logic [30:0] ent_tick[NENT];
  logic [3:0] ent_hits[NENT];
  logic ent_pf[NENT];
  logic [31:0] tgt_addr[NENT][NTGT];
  logic tgt_valid[NENT][NTGT];
  logic pf_flag;

  outcome_t pending_outcomes[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  initial forever #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("indirect_pattern_table_tb: errors");
      $finish;
    end
  end

  function automatic bit target_present(int e, logic [31:0] a);
    for (int t = 0; t < NTGT; t++)
      if (tgt_valid[e][t] && tgt_addr[e][t] == a) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void drop_targets(int e);
    for (int t = 0; t < NTGT; t++) tgt_valid[e][t] = 1'b0;
  endfunction

  function automatic void clear_table();
    for (int e = 0; e < NENT; e++) begin
      ent_valid[e] = 1'b0;
      drop_targets(e);
    end
    pf_flag = 1'b0;
    cur_interval = ipt_pkg::INTERVAL_RST;
    cur_window = ipt_pkg::WINDOW_RST;
    cur_phits = ipt_pkg::PHITS_RST;
  endfunction

  function automatic outcome_t predict_outcome(logic act, logic [30:0] addr,
      logic [31:0] value, logic [30:0] tk, logic [30:0] base, logic [30:0] iaddr);
    outcome_t r;
    int found;
    int free_slot;
    longint gap;
    logic [31:0] tgt;
    r = '0;
    found = -1;
    free_slot = -1;
    if (act == ipt_pkg::ACT_ADD) begin
      for (int e = 0; e < NENT; e++) begin
        if (ent_valid[e] && ent_base[e] == base && found < 0) found = e;
        if (!ent_valid[e] && free_slot < 0) free_slot = e;
      end
      if (found >= 0) begin
        ent_last[found] = iaddr;
        ent_tick[found] = tk;
      end else if (free_slot >= 0) begin
        ent_valid[free_slot] = 1'b1;
        ent_base[free_slot] = base;
        ent_last[free_slot] = iaddr;
        ent_tick[free_slot] = tk;
        ent_hits[free_slot] = '0;
        ent_pf[free_slot] = 1'b0;
        drop_targets(free_slot);
        r.created = 1'b1;
      end else begin
        r.dropped = 1'b1;
      end
    end else begin
      for (int e = 0; e < NENT; e++) begin
        if (!ent_valid[e] || ent_pf[e]) continue;
        gap = longint'(addr) - longint'(ent_last[e]);
        if (gap <= longint'(cur_window)) begin
          tgt = value * 32'd4 + {1'b0, ent_base[e]};
          if (!target_present(e, tgt)) begin
            for (int t = 0; t < NTGT; t++)
              if (!tgt_valid[e][t]) begin
                tgt_valid[e][t] = 1'b1;
                tgt_addr[e][t] = tgt;
                break;
              end
          end
          ent_last[e] = addr;
          r.is_index = 1'b1;
        end
      end
      if (!r.is_index) begin
        for (int e = 0; e < NENT; e++) begin
          if (!ent_valid[e]) continue;
          if (target_present(e, {1'b0, addr})) begin
            if (ent_hits[e] < ipt_pkg::HIT_MAX) ent_hits[e]++;
            if (ent_hits[e] > cur_phits) begin
              ent_pf[e] = 1'b1;
              pf_flag = 1'b1;
              ent_tick[e] = tk;
              drop_targets(e);
              r.started = 1'b1;
            end
          end
          if (longint'(tk) - longint'(ent_tick[e]) > 5 * longint'(cur_interval) &&
              !ent_pf[e] && ent_hits[e] < ipt_pkg::STALE_HITS) begin
            ent_valid[e] = 1'b0;
            drop_targets(e);
            if (r.removed < ipt_pkg::REM_MAX) r.removed++;
          end
        end
      end
    end
    r.pf_on = pf_flag;
    return r;
  endfunction

  task automatic send_item(logic act, logic [30:0] addr, logic [31:0] value,
      logic [30:0] tk, logic [30:0] base, logic [30:0] iaddr);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {4'b0, iaddr, base, tk, value, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_outcomes.push_front(predict_outcome(act, addr, value, tk, base, iaddr));
    @(negedge clk);
    s_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  // Receiver handshake and result check.
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_off > 0) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    outcome_t want;
    if (hold_off > 0) hold_off <= hold_off - 1;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_outcomes.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer %h", m_tdata);
      end else begin
        want = pending_outcomes.pop_back();
        if (m_tdata[9:0] !== want || m_tdata[15:10] !== 6'd0) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %h (idx %b st %b on %b rem %0d cr %b dr %b) got %h",
                     want, want.is_index, want.started, want.pf_on, want.removed,
                     want.created, want.dropped, m_tdata);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ipt_pkg::AW'(idx) << 2;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      ipt_pkg::REG_INTERVAL: cur_interval = val[9:0];
      ipt_pkg::REG_WINDOW: cur_window = val[11:0];
      default: cur_phits = val[3:0];
    endcase
  endtask

  function automatic logic [30:0] rand31();
    return 31'($urandom);
  endfunction

  task automatic test_directed();
    send_item(ipt_pkg::ACT_ACCESS, '1, '1, '1, '1, '1);
    send_item(ipt_pkg::ACT_ADD, 31'd1000, '0, 31'd0, 31'd4096, 31'd2000);
    send_item(ipt_pkg::ACT_ADD, 31'd0, '0, 31'd3, 31'd4096, 31'd2010);
    send_item(ipt_pkg::ACT_ACCESS, 31'd2020, 32'd5, 31'd4, '0, '0);
    send_item(ipt_pkg::ACT_ACCESS, 31'd0, 32'd6, 31'd4, '0, '0);
    send_item(ipt_pkg::ACT_ACCESS, 31'd2200, 32'h8000_0000, 31'd4, '0, '0);
    send_item(ipt_pkg::ACT_ACCESS, 31'd2201, 32'h7FFF_FFFF, 31'd4, '0, '0);
    for (int i = 0; i < 6; i++) send_item(ipt_pkg::ACT_ACCESS, 31'd4116, '0, 31'd5, '0, '0);
    send_item(ipt_pkg::ACT_ACCESS, 31'h7FFF_FFFF, '0, 31'h7FFF_FFFF, '0, '0);
    for (int i = 0; i < 17; i++)
      send_item(ipt_pkg::ACT_ADD, '0, '1, 31'(i), 31'(i * 64), 31'h7FFF_FFF0);
    send_item(ipt_pkg::ACT_ACCESS, 31'h4000_0000, '0, 31'h7FFF_FFFF, '0, '0);
  endtask

  // Mostly well-formed traffic: adds around a few bases, accesses near last index
  // and at recorded targets so that hits and prefetching occur, plus random items.
  task automatic test_random(int count);
    logic [30:0] bases[4];
    logic [30:0] idx_addr[4];
    logic [31:0] vals[4];
    logic [30:0] tk;
    int k;
    int pick;
    tk = 31'($urandom_range(1000));
    for (int i = 0; i < 4; i++) begin
      bases[i] = 31'($urandom_range(1 << 20)) << 2;
      idx_addr[i] = 31'($urandom_range(32'h7000_0000));
      vals[i] = $urandom_range(255);
    end
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(3);
      tk = tk + 31'($urandom_range(4));
      pick = $urandom_range(99);
      if (pick < 15)
        send_item(ipt_pkg::ACT_ADD, rand31(), $urandom, tk, bases[k], idx_addr[k]);
      else if (pick < 45) begin
        idx_addr[k] = idx_addr[k] + 31'($urandom_range(8));
        vals[k] = $urandom_range(255);
        send_item(ipt_pkg::ACT_ACCESS, idx_addr[k], vals[k], tk, rand31(), rand31());
      end else if (pick < 80)
        send_item(ipt_pkg::ACT_ACCESS,
                  bases[k] + 31'(vals[$urandom_range(3)] * 4) + 31'h0800_0000,
                  $urandom, tk, rand31(), rand31());
      else if (pick < 90)
        send_item(ipt_pkg::ACT_ACCESS, bases[k] + 31'(vals[k] * 4), $urandom, tk,
                  rand31(), rand31());
      else if (pick < 95)
        send_item(ipt_pkg::ACT_ADD, rand31(), $urandom, rand31(), rand31(), rand31());
      else
        send_item(ipt_pkg::ACT_ACCESS, rand31(), $urandom, rand31(), rand31(), rand31());
      if ($urandom_range(49) == 0) begin
        bases[k] = rand31();
        idx_addr[k] = 31'($urandom_range(32'h7000_0000));
      end
    end
  endtask

  task automatic test_backpressure();
    hold_off = 400;
    test_random(40);
  endtask

  initial begin
    clear_table();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    write_reg(ipt_pkg::REG_INTERVAL, 32'd1);
    write_reg(ipt_pkg::REG_WINDOW, 32'd0);
    write_reg(ipt_pkg::REG_PHITS, 32'd1);
    test_random(300);
    send_idle_pct = 47;
    write_reg(ipt_pkg::REG_INTERVAL, 32'd1023);
    write_reg(ipt_pkg::REG_WINDOW, 32'd4095);
    write_reg(ipt_pkg::REG_PHITS, 32'd15);
    test_random(450);
    send_idle_pct = 0;
    recv_stall_pct = 47;
    write_reg(ipt_pkg::REG_INTERVAL, 32'd3);
    write_reg(ipt_pkg::REG_WINDOW, 32'd64);
    write_reg(ipt_pkg::REG_PHITS, 32'd2);
    test_random(450);
    send_idle_pct = 38;
    recv_stall_pct = 38;
    test_random(450);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    wait_drained();
    repeat (100) @(negedge clk);
    if (errors == 0 && pending_outcomes.size() == 0) begin
      $display("indirect_pattern_table_tb: clean");
    end else begin
      $display("indirect_pattern_table_tb: errors");
    end
    $finish;
  end

endmodule
